// ===== rtl/lagrange_line_basis_eval_defines.svh =====
// ----------------------------------------------------------------------------
// Lagrange line basis evaluator: assertion macros
// Shared concurrent assertion shorthands for the evaluator RTL.
// ----------------------------------------------------------------------------
`ifndef LAGRANGE_LINE_BASIS_EVAL_DEFINES_SVH
`define LAGRANGE_LINE_BASIS_EVAL_DEFINES_SVH

// same-cycle implication
`define LLE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LLE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/lle_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lagrange line basis evaluator package
// Types, widths and coefficient tables shared by the evaluator modules.
// ----------------------------------------------------------------------------
package lle_pkg;

	localparam int MAX_ORDER = 5;
	localparam int NOUT      = 6;
	localparam int NCOEF     = 6;
	localparam int CW        = 19;
	localparam int AW        = 45;
	localparam int PW        = 17;
	localparam int OW        = 32;
	localparam int ORDW      = 3;
	localparam int ALW       = 22;
	localparam int AHW       = AW - ALW;
	localparam int PHW       = AHW + PW + 1;
	localparam int PLW       = ALW + PW;
	localparam int TW        = 33;
	localparam int ONE_POS   = 65536;
	localparam int RECIP3    = 349526;
	localparam int RSH3      = 20;

	typedef enum logic [1:0] {
		OP_VAL = 2'd0,
		OP_D1  = 2'd1,
		OP_D2  = 2'd2,
		OP_NONE = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		DIV_16  = 2'd0,
		DIV_32  = 2'd1,
		DIV_48  = 2'd2,
		DIV_384 = 2'd3
	} dsel_t;

	typedef logic signed [CW-1:0] coef_t;
	typedef logic signed [AW-1:0] acc_t;

	typedef struct packed {
		logic [1:0]    opcode;
		logic [PW-1:0] position;
	} in_item_t;

	typedef struct packed {
		logic signed [OW-1:0] basis_0;
		logic signed [OW-1:0] basis_1;
		logic signed [OW-1:0] basis_2;
		logic signed [OW-1:0] basis_3;
		logic signed [OW-1:0] basis_4;
		logic signed [OW-1:0] basis_5;
	} out_item_t;

	typedef struct packed {
		logic [PW-1:0]                     pos;
		dsel_t                             dsel;
		coef_t [NOUT-1:0][NCOEF-1:0]       c;
		acc_t  [NOUT-1:0]                  acc;
	} work_t;

	localparam int VCOEF [0:4][0:5][0:5] = '{
		'{ '{1, -1, 0, 0, 0, 0}, '{0, 1, 0, 0, 0, 0}, '{0, 0, 0, 0, 0, 0},
		   '{0, 0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0, 0} },
		'{ '{1, -3, 2, 0, 0, 0}, '{0, -1, 2, 0, 0, 0}, '{0, 4, -4, 0, 0, 0},
		   '{0, 0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0, 0} },
		'{ '{2, -11, 18, -9, 0, 0}, '{0, 2, -9, 9, 0, 0}, '{0, 18, -45, 27, 0, 0},
		   '{0, -9, 36, -27, 0, 0}, '{0, 0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0, 0} },
		'{ '{3, -25, 70, -80, 32, 0}, '{0, -3, 22, -48, 32, 0},
		   '{0, 48, -208, 288, -128, 0}, '{0, -36, 228, -384, 192, 0},
		   '{0, 16, -112, 224, -128, 0}, '{0, 0, 0, 0, 0, 0} },
		'{ '{24, -274, 1125, -2125, 1875, -625}, '{0, 24, -250, 875, -1250, 625},
		   '{0, 600, -3850, 8875, -8750, 3125}, '{0, -600, 5350, -14750, 16250, -6250},
		   '{0, 400, -3900, 12250, -15000, 6250}, '{0, -150, 1525, -5125, 6875, -3125} }
	};

	function automatic coef_t coef_of(input logic [ORDW-1:0] ord, input opcode_t op,
			input int j, input int k);
		int oi;
		int v;
		oi = int'(ord) - 1;
		v  = 0;
		case (op)
			OP_VAL: v = VCOEF[oi][j][k];
			OP_D1:  v = (k + 1 < NCOEF) ? (k + 1) * VCOEF[oi][j][k + 1] : 0;
			OP_D2:  v = (k + 2 < NCOEF) ? (k + 2) * (k + 1) * VCOEF[oi][j][k + 2] : 0;
			default: v = 0;
		endcase
		return CW'(v);
	endfunction

endpackage

// ===== rtl/lagrange_line_basis_eval.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lagrange line basis evaluator
// Equispaced Lagrange basis values and derivatives on [0,1], orders 1 to 5.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  in      | in_valid / in_ready  | in_data   (opcode, position)
//  out     | out_valid / out_ready| out_data  (basis_0 .. basis_5)
//  cfg     | cfg_valid / cfg_ready| cfg_data  (poly_order)
//
//  One transaction per cycle unless the output stalls. Stages: coefficient
//  lookup, five two-stage Horner steps (one multiply stage, one round-add
//  stage), three scaling stages. The whole pipeline holds while the output
//  register is full and not taken. Reset sets poly_order to 1 and empties
//  the pipeline. cfg_ready is always high.
// ----------------------------------------------------------------------------
`include "lagrange_line_basis_eval_defines.svh"

module lagrange_line_basis_eval (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  lle_pkg::in_item_t         in_data,
	output logic                      out_valid,
	input  logic                      out_ready,
	output lle_pkg::out_item_t        out_data,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [lle_pkg::ORDW-1:0]  cfg_data
);

	localparam int NSTEP = lle_pkg::NCOEF - 1;

	logic [lle_pkg::ORDW-1:0] poly_order_q;
	logic                     en;
	logic                     v [NSTEP+1];
	lle_pkg::work_t           w [NSTEP+1];

	assign en        = !out_valid || out_ready;
	assign in_ready  = en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_order_q <= lle_pkg::ORDW'(1);
		end else if (cfg_valid && cfg_ready) begin
			poly_order_q <= cfg_data;
		end
	end

	lle_coef u_coef (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.valid_in   (in_valid),
		.item       (in_data),
		.poly_order (poly_order_q),
		.valid_out  (v[0]),
		.work_out   (w[0])
	);

	for (genvar i = 0; i < NSTEP; i++) begin : g_step
		lle_horner_step u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.valid_in  (v[i]),
			.work_in   (w[i]),
			.valid_out (v[i+1]),
			.work_out  (w[i+1])
		);
	end

	lle_norm u_norm (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid_in  (v[NSTEP]),
		.work_in   (w[NSTEP]),
		.valid_out (out_valid),
		.result    (out_data)
	);

	`LLE_ASSERT_NOW(a_empty_takes, clk, arst_n, !out_valid, in_ready, "empty output blocks input")
	`LLE_ASSERT_NOW(a_cfg_ready, clk, arst_n, cfg_valid, cfg_ready, "config write refused")
	`LLE_ASSERT_NEXT(a_stall_holds, clk, arst_n, out_valid && !out_ready, out_valid, "result lost in stall")

endmodule

// ===== rtl/lle_coef.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coefficient select stage
// Saturates the position, looks up per-output coefficients and seeds Horner.
// ----------------------------------------------------------------------------
module lle_coef (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      valid_in,
	input  lle_pkg::in_item_t         item,
	input  logic [lle_pkg::ORDW-1:0]  poly_order,
	output logic                      valid_out,
	output lle_pkg::work_t            work_out
);

	logic                     valid_s1;
	lle_pkg::work_t           work_s1;
	lle_pkg::work_t           work_d;
	logic [lle_pkg::ORDW-1:0] ord;
	lle_pkg::opcode_t         op;
	logic                     live;

	always_comb begin
		if (poly_order == '0) begin
			ord = lle_pkg::ORDW'(1);
		end else if (poly_order > lle_pkg::ORDW'(lle_pkg::MAX_ORDER)) begin
			ord = lle_pkg::ORDW'(lle_pkg::MAX_ORDER);
		end else begin
			ord = poly_order;
		end
		op = lle_pkg::opcode_t'(item.opcode);
		work_d = '0;
		if (item.position > lle_pkg::PW'(lle_pkg::ONE_POS)) begin
			work_d.pos = lle_pkg::PW'(lle_pkg::ONE_POS);
		end else begin
			work_d.pos = item.position;
		end
		case (ord)
			3'd1, 3'd2: work_d.dsel = lle_pkg::DIV_16;
			3'd3:       work_d.dsel = lle_pkg::DIV_32;
			3'd4:       work_d.dsel = lle_pkg::DIV_48;
			default:    work_d.dsel = lle_pkg::DIV_384;
		endcase
		for (int j = 0; j < lle_pkg::NOUT; j++) begin
			live = (op != lle_pkg::OP_NONE) && (j <= int'(ord));
			for (int k = 0; k < lle_pkg::NCOEF; k++) begin
				work_d.c[j][k] = live ? lle_pkg::coef_of(ord, op, j, k) : '0;
			end
			work_d.acc[j] = lle_pkg::AW'($signed(work_d.c[j][lle_pkg::NCOEF-1])) <<< 24;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			work_s1 <= work_d;
		end
	end

	assign valid_out = valid_s1;
	assign work_out  = work_s1;

endmodule

// ===== rtl/lle_horner_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Horner step
// One multiply-round-add step for all six outputs, over two stages.
// ----------------------------------------------------------------------------
module lle_horner_step (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           valid_in,
	input  lle_pkg::work_t work_in,
	output logic           valid_out,
	output lle_pkg::work_t work_out
);

	logic                                    valid_s1;
	logic                                    valid_s2;
	lle_pkg::work_t                          work_s1;
	lle_pkg::work_t                          work_s2;
	logic signed [lle_pkg::PHW-1:0]          ph_s1 [lle_pkg::NOUT];
	logic        [lle_pkg::PLW-1:0]          pl_s1 [lle_pkg::NOUT];
	logic signed [lle_pkg::PHW-1:0]          ph_d  [lle_pkg::NOUT];
	logic        [lle_pkg::PLW-1:0]          pl_d  [lle_pkg::NOUT];
	lle_pkg::work_t                          work_d;
	logic signed [63:0]                      x;
	logic signed [63:0]                      rnd;
	logic signed [63:0]                      q;

	always_comb begin
		for (int j = 0; j < lle_pkg::NOUT; j++) begin
			ph_d[j] = $signed(work_in.acc[j][lle_pkg::AW-1:lle_pkg::ALW])
				* $signed({1'b0, work_in.pos});
			pl_d[j] = lle_pkg::PLW'(work_in.acc[j][lle_pkg::ALW-1:0]) * lle_pkg::PLW'(work_in.pos);
		end
	end

	always_comb begin
		work_d = work_s1;
		x = '0;
		rnd = '0;
		q = '0;
		for (int j = 0; j < lle_pkg::NOUT; j++) begin
			x   = (64'(ph_s1[j]) <<< lle_pkg::ALW) + $signed(64'(pl_s1[j]));
			rnd = x + 64'sd32768 - $signed({63'b0, x[63]});
			q   = rnd >>> 16;
			work_d.acc[j] = lle_pkg::AW'(q)
				+ (lle_pkg::AW'($signed(work_s1.c[j][lle_pkg::NCOEF-2])) <<< 24);
			for (int k = lle_pkg::NCOEF - 1; k > 0; k--) begin
				work_d.c[j][k] = work_s1.c[j][k-1];
			end
			work_d.c[j][0] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_in;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			work_s1 <= work_in;
			ph_s1   <= ph_d;
			pl_s1   <= pl_d;
			work_s2 <= work_d;
		end
	end

	assign valid_out = valid_s2;
	assign work_out  = work_s2;

endmodule

// ===== rtl/lle_norm.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Output scaling
// Rounds the accumulators by the order divisor into Q11.20, three stages.
// ----------------------------------------------------------------------------
module lle_norm (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               valid_in,
	input  lle_pkg::work_t     work_in,
	output logic               valid_out,
	output lle_pkg::out_item_t result
);

	localparam int HW = lle_pkg::TW - 16;

	logic                         valid_s1, valid_s2, valid_s3;
	logic                         need3_s1, need3_s2;
	logic [lle_pkg::NOUT-1:0]     neg_s1, neg_s2;
	logic [lle_pkg::TW-1:0]       t_s1 [lle_pkg::NOUT];
	logic [lle_pkg::TW-1:0]       t_s2 [lle_pkg::NOUT];
	logic [15:0]                  qh_s2 [lle_pkg::NOUT];
	logic [1:0]                   rh_s2 [lle_pkg::NOUT];
	logic signed [lle_pkg::OW-1:0] r_s3 [lle_pkg::NOUT];

	logic [lle_pkg::NOUT-1:0]     neg_d;
	logic [lle_pkg::TW-1:0]       t_d  [lle_pkg::NOUT];
	logic [15:0]                  qh_d [lle_pkg::NOUT];
	logic [1:0]                   rh_d [lle_pkg::NOUT];
	logic signed [lle_pkg::OW-1:0] r_d [lle_pkg::NOUT];
	logic [lle_pkg::AW:0]         mag;
	logic [lle_pkg::AW:0]         sum;
	logic [HW-1:0]                vh;
	logic [35:0]                  ph;
	logic [16:0]                  three_q;
	logic [36:0]                  pl;
	logic [lle_pkg::TW-1:0]       q;

	always_comb begin
		mag = '0;
		sum = '0;
		for (int j = 0; j < lle_pkg::NOUT; j++) begin
			neg_d[j] = work_in.acc[j][lle_pkg::AW-1];
			mag = neg_d[j] ? -{1'b1, work_in.acc[j]} : {1'b0, work_in.acc[j]};
			case (work_in.dsel)
				lle_pkg::DIV_16: begin
					sum = mag + (lle_pkg::AW+1)'(8);
					t_d[j] = sum[lle_pkg::TW+3:4];
				end
				lle_pkg::DIV_32: begin
					sum = mag + (lle_pkg::AW+1)'(16);
					t_d[j] = sum[lle_pkg::TW+4:5];
				end
				lle_pkg::DIV_48: begin
					sum = mag + (lle_pkg::AW+1)'(24);
					t_d[j] = sum[lle_pkg::TW+3:4];
				end
				default: begin
					sum = mag + (lle_pkg::AW+1)'(192);
					t_d[j] = sum[lle_pkg::TW+6:7];
				end
			endcase
		end
	end

	always_comb begin
		vh = '0;
		ph = '0;
		three_q = '0;
		for (int j = 0; j < lle_pkg::NOUT; j++) begin
			vh = t_s1[j][lle_pkg::TW-1:16];
			ph = 36'(vh) * 36'(lle_pkg::RECIP3);
			qh_d[j] = ph[35:lle_pkg::RSH3];
			three_q = 17'(qh_d[j]) + {qh_d[j], 1'b0};
			rh_d[j] = 2'(vh - three_q);
		end
	end

	always_comb begin
		pl = '0;
		q = '0;
		for (int j = 0; j < lle_pkg::NOUT; j++) begin
			pl = 37'({rh_s2[j], t_s2[j][15:0]}) * 37'(lle_pkg::RECIP3);
			if (need3_s2) begin
				q = {1'b0, qh_s2[j], 16'b0} + lle_pkg::TW'(pl[36:lle_pkg::RSH3]);
			end else begin
				q = t_s2[j];
			end
			r_d[j] = neg_s2[j] ? -lle_pkg::OW'(q) : lle_pkg::OW'(q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_in;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			need3_s1 <= (work_in.dsel == lle_pkg::DIV_48) || (work_in.dsel == lle_pkg::DIV_384);
			neg_s1   <= neg_d;
			t_s1     <= t_d;
			need3_s2 <= need3_s1;
			neg_s2   <= neg_s1;
			t_s2     <= t_s1;
			qh_s2    <= qh_d;
			rh_s2    <= rh_d;
			r_s3     <= r_d;
		end
	end

	assign valid_out      = valid_s3;
	assign result.basis_0 = r_s3[0];
	assign result.basis_1 = r_s3[1];
	assign result.basis_2 = r_s3[2];
	assign result.basis_3 = r_s3[3];
	assign result.basis_4 = r_s3[4];
	assign result.basis_5 = r_s3[5];

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lagrange line basis evaluator testbench
// Drives positions and opcodes through the evaluator under every basis order,
// predicts each basis vector in fixed point and compares it field by field.
// ----------------------------------------------------------------------------
module testbench;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 20;
	localparam int CFG_INDEX      = 0;

	localparam int BASIS_TAB [0:4][0:5][0:5] = '{
		'{ '{1, -1, 0, 0, 0, 0}, '{0, 1, 0, 0, 0, 0}, '{0, 0, 0, 0, 0, 0},
		   '{0, 0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0, 0} },
		'{ '{1, -3, 2, 0, 0, 0}, '{0, -1, 2, 0, 0, 0}, '{0, 4, -4, 0, 0, 0},
		   '{0, 0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0, 0} },
		'{ '{2, -11, 18, -9, 0, 0}, '{0, 2, -9, 9, 0, 0}, '{0, 18, -45, 27, 0, 0},
		   '{0, -9, 36, -27, 0, 0}, '{0, 0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0, 0} },
		'{ '{3, -25, 70, -80, 32, 0}, '{0, -3, 22, -48, 32, 0},
		   '{0, 48, -208, 288, -128, 0}, '{0, -36, 228, -384, 192, 0},
		   '{0, 16, -112, 224, -128, 0}, '{0, 0, 0, 0, 0, 0} },
		'{ '{24, -274, 1125, -2125, 1875, -625}, '{0, 24, -250, 875, -1250, 625},
		   '{0, 600, -3850, 8875, -8750, 3125}, '{0, -600, 5350, -14750, 16250, -6250},
		   '{0, 400, -3900, 12250, -15000, 6250}, '{0, -150, 1525, -5125, 6875, -3125} }
	};
	localparam longint ORDER_DIV [0:4] = '{1, 1, 2, 3, 24};

	logic                        clk;
	logic                        arst_n;
	logic                        in_valid;
	logic                        in_ready;
	lle_pkg::in_item_t           in_data;
	logic                        out_valid;
	logic                        out_ready;
	lle_pkg::out_item_t          out_data;
	logic                        cfg_valid;
	logic                        cfg_ready;
	logic [lle_pkg::ORDW-1:0]    cfg_data;

	logic [lle_pkg::ORDW-1:0]    order_reg;
	lle_pkg::out_item_t          basis_q[$];
	int                          err_cnt;
	int                          idle_cycles;
	int                          burst_left;
	int                          stall_mode;
	int                          stall_timer;

	lagrange_line_basis_eval dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	function automatic longint round_near(longint num, longint den);
		longint mag;
		mag = (num < 0) ? -num : num;
		mag = (mag + den / 2) / den;
		return (num < 0) ? -mag : mag;
	endfunction

	function automatic lle_pkg::out_item_t basis_vector(logic [lle_pkg::ORDW-1:0] ord_raw,
			logic [1:0] op, logic [lle_pkg::PW-1:0] pos_raw);
		int        ord;
		longint    pos;
		longint    cf [0:5];
		longint    acc;
		logic signed [lle_pkg::OW-1:0] res [0:5];
		lle_pkg::out_item_t r;
		ord = (ord_raw < 1) ? 1 : (ord_raw > lle_pkg::MAX_ORDER) ? lle_pkg::MAX_ORDER
			: int'(ord_raw);
		pos = (pos_raw > lle_pkg::ONE_POS) ? lle_pkg::ONE_POS : longint'(pos_raw);
		for (int j = 0; j < 6; j++) begin
			res[j] = '0;
			if (op != lle_pkg::OP_NONE && j <= ord) begin
				for (int k = 0; k < 6; k++) begin
					case (lle_pkg::opcode_t'(op))
						lle_pkg::OP_VAL: cf[k] = BASIS_TAB[ord-1][j][k];
						lle_pkg::OP_D1:  cf[k] = (k < 5) ? (k + 1) * BASIS_TAB[ord-1][j][k+1] : 0;
						default: cf[k] = (k < 4) ?
							(k + 2) * (k + 1) * BASIS_TAB[ord-1][j][k+2] : 0;
					endcase
				end
				acc = cf[5] * 64'd16777216;
				for (int k = 4; k >= 0; k--)
					acc = round_near(acc * pos, 65536) + cf[k] * 64'd16777216;
				res[j] = lle_pkg::OW'(round_near(acc, 16 * ORDER_DIV[ord-1]));
			end
		end
		r.basis_0 = res[0];
		r.basis_1 = res[1];
		r.basis_2 = res[2];
		r.basis_3 = res[3];
		r.basis_4 = res[4];
		r.basis_5 = res[5];
		return r;
	endfunction

	// predict at input acceptance, check at output acceptance
	always @(posedge clk) begin
		lle_pkg::out_item_t exp_v;
		if (arst_n) begin
			if (in_valid && in_ready)
				basis_q.push_back(basis_vector(order_reg, in_data.opcode, in_data.position));
			if (out_valid && out_ready) begin
				if (basis_q.size() == 0) begin
					$error("unexpected output transaction");
					err_cnt++;
				end else begin
					exp_v = basis_q.pop_front();
					if (out_data.basis_0 !== exp_v.basis_0) begin
						$error("basis_0 exp %0d got %0d", exp_v.basis_0, out_data.basis_0);
						err_cnt++;
					end
					if (out_data.basis_1 !== exp_v.basis_1) begin
						$error("basis_1 exp %0d got %0d", exp_v.basis_1, out_data.basis_1);
						err_cnt++;
					end
					if (out_data.basis_2 !== exp_v.basis_2) begin
						$error("basis_2 exp %0d got %0d", exp_v.basis_2, out_data.basis_2);
						err_cnt++;
					end
					if (out_data.basis_3 !== exp_v.basis_3) begin
						$error("basis_3 exp %0d got %0d", exp_v.basis_3, out_data.basis_3);
						err_cnt++;
					end
					if (out_data.basis_4 !== exp_v.basis_4) begin
						$error("basis_4 exp %0d got %0d", exp_v.basis_4, out_data.basis_4);
						err_cnt++;
					end
					if (out_data.basis_5 !== exp_v.basis_5) begin
						$error("basis_5 exp %0d got %0d", exp_v.basis_5, out_data.basis_5);
						err_cnt++;
					end
				end
			end
		end
	end

	// receiver stall pattern: free running, random, or long stalls
	always @(posedge clk) begin
		if (stall_timer == 0) begin
			stall_mode  <= $urandom_range(0, 2);
			stall_timer <= $urandom_range(20, 80);
		end else begin
			stall_timer <= stall_timer - 1;
		end
		case (stall_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= 1'($urandom_range(0, 1));
			default: out_ready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic send_item(logic [1:0] op, logic [lle_pkg::PW-1:0] pos);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		in_data  <= '{opcode: op, position: pos};
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (basis_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_order(logic [lle_pkg::ORDW-1:0] v);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		order_reg = v;
	endtask

	function automatic logic [lle_pkg::PW-1:0] rand_position();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return lle_pkg::PW'(lle_pkg::ONE_POS);
			2: return lle_pkg::PW'($urandom_range(lle_pkg::ONE_POS + 1, 2 ** lle_pkg::PW - 1));
			default: return lle_pkg::PW'($urandom_range(0, lle_pkg::ONE_POS));
		endcase
	endfunction

	task automatic test_reset_order();
		for (int op = 0; op < 4; op++)
			send_item(2'(op), lle_pkg::PW'(16'h8000));
	endtask

	task automatic test_extremes();
		for (int ord = 0; ord < 8; ord++) begin
			write_order(lle_pkg::ORDW'(ord));
			for (int op = 0; op < 4; op++) begin
				send_item(2'(op), '0);
				send_item(2'(op), lle_pkg::PW'(lle_pkg::ONE_POS));
				if (ord == 5 || ord == 0) begin
					send_item(2'(op), lle_pkg::PW'(2 ** lle_pkg::PW - 1));
					send_item(2'(op), 17'h15555);
				end
			end
		end
	endtask

	task automatic test_random();
		for (int ph = 0; ph < 12; ph++) begin
			write_order(lle_pkg::ORDW'((ph % 4 == 3) ? $urandom_range(0, 7)
				: $urandom_range(1, 5)));
			repeat (64)
				send_item(2'(($urandom_range(0, 15) == 0) ? lle_pkg::OP_NONE
					: $urandom_range(0, 2)), rand_position());
		end
	endtask

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		in_data     = '0;
		out_ready   = 1'b0;
		cfg_valid   = 1'b0;
		cfg_data    = '0;
		order_reg   = lle_pkg::ORDW'(1);
		err_cnt     = 0;
		idle_cycles = 0;
		burst_left  = 0;
		stall_mode  = 0;
		stall_timer = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_order();
		test_extremes();
		test_random();
		wait_idle();
		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
